// File: rtl/multi_channel_led_blinker_assert.svh
// Assertion macros shared by the blinker RTL.
`ifndef MULTI_CHANNEL_LED_BLINKER_ASSERT_SVH
`define MULTI_CHANNEL_LED_BLINKER_ASSERT_SVH
`ifndef SYNTHESIS
`define MCLB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MCLB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MCLB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MCLB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/mclb_pkg.sv
package mclb_pkg;

    localparam int CHANNELS_DEF = 6;
    localparam int OP_W         = 2;
    localparam int CH_W         = 3;
    localparam int MS_W         = 16;
    localparam int PAT_W        = 6;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 8;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;
    localparam logic [OP_W-1:0] OP_SET   = 2'd3;

    localparam logic [MS_W-1:0] MS_MAX        = 16'hffff;
    // even channels lit after reset
    localparam logic [31:0]     EVEN_LIT_MASK = 32'h5555_5555;

    typedef struct packed {
        logic             pins_written;
        logic [PAT_W-1:0] led_pattern;
    } t_result;

endpackage

// File: rtl/multi_channel_led_blinker.sv
// Six-channel (CHANNELS) LED blink controller. One transaction is accepted per clock
// cycle while tready is high: the channel state is updated in the cycle of acceptance
// and its result goes into a two-entry output buffer: the result register, or the skid
// register while the result register holds an untaken result. Input continues while a
// result waits; tready drops only when both entries hold untaken results. Throughput is
// set by the single pass through the per-channel counter compare logic. Channel state
// and valid flags are in flip-flops cleared by reset, no start-up sweep.
`include "multi_channel_led_blinker_assert.svh"

module multi_channel_led_blinker #(
    parameter int CHANNELS = mclb_pkg::CHANNELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // op[1:0], channel[4:2], on_ms[20:5], off_ms[36:21], level[37], zero pad
    input  logic [mclb_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // led_pattern[5:0], pins_written[6], zero pad
    output logic [mclb_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);
    import mclb_pkg::*;

    localparam logic [CHANNELS-1:0] LEVELS_RST = CHANNELS'(EVEN_LIT_MASK);
    localparam logic [5:0]          CH_LIMIT   = 6'(CHANNELS);

    logic [CHANNELS-1:0]           r_levels, n_levels;
    logic [CHANNELS-1:0]           r_active, n_active;
    logic [CHANNELS-1:0][MS_W-1:0] r_lit_dur, n_lit_dur;
    logic [CHANNELS-1:0][MS_W-1:0] r_dark_dur, n_dark_dur;
    logic [CHANNELS-1:0][MS_W-1:0] r_elapsed, n_elapsed;
    logic [CHANNELS-1:0]           r_shown, n_shown;
    logic                          r_shown_valid, n_shown_valid;

    logic                          r_out_valid, r_skid_valid;
    t_result                       r_out, r_skid;
    t_result                       n_result;

    logic                          w_accept;
    logic [OP_W-1:0]               w_op;
    logic [CH_W-1:0]               w_ch;
    logic [MS_W-1:0]               w_on_ms, w_off_ms;
    logic                          w_level;
    logic [CHANNELS-1:0]           w_sel;
    logic [CHANNELS+PAT_W-1:0]     w_lv_pad;

    assign w_op     = i_s_axis_tdata[1:0];
    assign w_ch     = i_s_axis_tdata[4:2];
    assign w_on_ms  = i_s_axis_tdata[20:5];
    assign w_off_ms = i_s_axis_tdata[36:21];
    assign w_level  = i_s_axis_tdata[37];

    assign o_s_axis_tready = !r_skid_valid;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // one-hot channel select, empty for channels beyond the bank
    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            w_sel[i] = ({3'b000, w_ch} == 6'(i)) && ({3'b000, w_ch} < CH_LIMIT);
        end
    end

    always_comb begin
        logic [MS_W-1:0] inc;
        n_levels      = r_levels;
        n_active      = r_active;
        n_lit_dur     = r_lit_dur;
        n_dark_dur    = r_dark_dur;
        n_elapsed     = r_elapsed;
        n_shown       = r_shown;
        n_shown_valid = r_shown_valid;
        n_result.pins_written = 1'b0;
        inc = '0;
        case (w_op)
            OP_TICK: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    inc = (r_elapsed[i] == MS_MAX) ? r_elapsed[i] : r_elapsed[i] + 1'b1;
                    if (r_active[i]) begin
                        n_elapsed[i] = inc;
                        if (r_levels[i] && inc >= r_lit_dur[i]) begin
                            n_levels[i]  = 1'b0;
                            n_elapsed[i] = '0;
                        end else if (!r_levels[i] && inc >= r_dark_dur[i]) begin
                            n_levels[i]  = 1'b1;
                            n_elapsed[i] = '0;
                        end
                    end
                end
                if (!r_shown_valid || r_shown != n_levels) begin
                    n_shown               = n_levels;
                    n_shown_valid         = 1'b1;
                    n_result.pins_written = 1'b1;
                end
            end
            OP_START: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (w_sel[i]) begin
                        n_lit_dur[i]  = w_on_ms;
                        n_dark_dur[i] = w_off_ms;
                        n_active[i]   = 1'b1;
                        n_elapsed[i]  = '0;
                        n_levels[i]   = 1'b1;
                    end
                end
            end
            OP_STOP: begin
                n_active = r_active & ~w_sel;
            end
            OP_SET: begin
                n_levels = w_level ? (r_levels | w_sel) : (r_levels & ~w_sel);
            end
            default: begin
                n_levels = r_levels;
            end
        endcase
        w_lv_pad             = {{PAT_W{1'b0}}, n_levels};
        n_result.led_pattern = w_lv_pad[PAT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels      <= LEVELS_RST;
            r_active      <= '0;
            r_lit_dur     <= '0;
            r_dark_dur    <= '0;
            r_elapsed     <= '0;
            r_shown       <= '0;
            r_shown_valid <= 1'b0;
        end else if (w_accept) begin
            r_levels      <= n_levels;
            r_active      <= n_active;
            r_lit_dur     <= n_lit_dur;
            r_dark_dur    <= n_dark_dur;
            r_elapsed     <= n_elapsed;
            r_shown       <= n_shown;
            r_shown_valid <= n_shown_valid;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_axis_tready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= n_result;
            end
        end else if (w_accept) begin
            r_skid <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out};

    `MCLB_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `MCLB_ASSERT_NXT(a_skid_holds, i_clk, i_rst_n, r_skid_valid && !i_m_axis_tready, r_skid_valid)
    `MCLB_ASSERT_NXT(a_tick_syncs_pins, i_clk, i_rst_n, w_accept && w_op == OP_TICK, r_shown_valid && r_shown == r_levels)
    `MCLB_ASSERT_NXT(a_start_lights, i_clk, i_rst_n, w_accept && w_op == OP_START, (r_levels & $past(w_sel)) == $past(w_sel) && (r_active & $past(w_sel)) == $past(w_sel))

endmodule
